FILE: design/rap_pkg.sv
package rap_pkg;

  localparam int CoordW = 13;
  localparam int CalcW  = 16;
  localparam logic [CoordW-1:0] CoordMax = 13'd8191;

  localparam logic [1:0] REQ_FIND    = 2'd0;
  localparam logic [1:0] REQ_PLACE   = 2'd1;
  localparam logic [1:0] REQ_RESET   = 2'd2;
  localparam logic [1:0] REQ_COMPACT = 2'd3;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SPLIT  = 2'd2;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic signed [CalcW-1:0] calc_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef struct packed {
    rect_t upd;
    logic  below;
    logic  app;
    rect_t app_rect;
  } cut_res_t;

  function automatic calc_t ext(input coord_t v);
    ext = calc_t'({3'b000, v});
  endfunction

  function automatic coord_t sat13(input calc_t v);
    if (v < 0) begin
      sat13 = '0;
    end else if (v > ext(CoordMax)) begin
      sat13 = CoordMax;
    end else begin
      sat13 = v[CoordW-1:0];
    end
  endfunction

endpackage

FILE: design/rap_in_if.sv
interface rap_in_if;
  import rap_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  coord_t     rect_x;
  coord_t     rect_y;
  coord_t     rect_w;
  coord_t     rect_h;
  modport source (output valid, req_type, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink (input valid, req_type, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

FILE: design/rap_out_if.sv
interface rap_out_if;
  import rap_pkg::*;
  logic       valid;
  logic       ready;
  logic       found;
  coord_t     place_x;
  coord_t     place_y;
  logic [7:0] space_count;
  logic       overflow;
  modport source (output valid, found, place_x, place_y, space_count, overflow, input ready);
  modport sink (input valid, found, place_x, place_y, space_count, overflow, output ready);
endinterface

FILE: design/rap_cfg_if.sv
interface rap_cfg_if;
  import rap_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  coord_t     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/rect_atlas_packer_core.sv
// Free-rectangle table for packing blocks into a 2D atlas.
// in_req: one request per item (find, place, table reset, compact). in_req.ready
// is high whenever the sequencer is idle; a finished result sits in the output
// register, so the next request may be taken while out_res waits.
// out_res: one result per request: found/place_x/place_y for find, the entry
// count and the sticky overflow flag for all requests.
// cfg_wr: register writes, ready outside reset; index 0 width, 1 height, 2 min split.
// Sequencing: find and compact walk every entry of the table, and a table reset
// rewrites entry 0 as it is accepted. A place runs two cut passes, each walking
// the table including every entry it appends on the way (no append when the
// table is full), then a strip entry if no entry lies at or below the line. A new
// request may be taken in the same cycle its result is presented. Each entry walked
// is one table read, plus one write for a place or a kept compact entry; one port each way.
// Reset clears the sequencer, loads the register defaults and marks the table
// as one entry; entry 0 is written with the whole atlas while reset is held.
// When out_res stalls, a finished result holds in the output register and the
// sequencer waits with the next result until the register is free.
module rect_atlas_packer_core
  import rap_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic clk,
  input  logic rst_n,
  rap_in_if.sink    in_req,
  rap_out_if.source out_res,
  rap_cfg_if.sink   cfg_wr
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_PROC  = 3'd2;
  localparam logic [2:0] S_APP   = 3'd3;
  localparam logic [2:0] S_STRIP = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    st_r, st_nxt;
  coord_t        aw_r, ah_r, ms_r;
  logic [1:0]    req_r, req_nxt;
  coord_t        bx_r, by_r, bw_r, bh_r, bx_nxt, by_nxt, bw_nxt, bh_nxt;
  logic [CW-1:0] idx_r, idx_nxt, cnt_r, cnt_nxt, j_r, j_nxt;
  logic          ovf_r, ovf_nxt, pass_r, pass_nxt, below_r, below_nxt;
  logic          bf_r, bf_nxt;
  coord_t        bestx_r, bestx_nxt, besty_r, besty_nxt;
  rect_t         app_r, app_nxt;
  logic          ov_r, ov_nxt, of_r, of_nxt;
  coord_t        ox_r, ox_nxt, oy_r, oy_nxt;
  logic [7:0]    oc_r, oc_nxt;
  logic          oo_r, oo_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  rect_t         wdata, rdata, strip;
  cut_res_t      cut;
  logic [CoordW+1:0] line;
  logic          drop;

  rap_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata
  );

  assign line = pass_r ? ((CoordW+2)'(by_r) + (CoordW+2)'(bh_r)) : (CoordW+2)'(by_r);

  rap_cut u_cut (
    .ent(rdata), .bx(bx_r), .bw(bw_r), .line(line), .strict(pass_r),
    .min_split(ms_r), .atlas_h(ah_r), .res(cut)
  );

  assign strip = '{x: '0, y: sat13(calc_t'({1'b0, line})), w: aw_r,
                   h: sat13(ext(ah_r) - calc_t'({1'b0, line}))};
  assign drop  = (rdata.x == '0) && (rdata.y == '0) && (rdata.w <= ms_r) &&
                 (rdata.h <= ms_r);

  assign in_req.ready = (st_r == S_IDLE) && rst_n;
  assign cfg_wr.ready = rst_n;

  assign out_res.valid       = ov_r;
  assign out_res.found       = of_r;
  assign out_res.place_x     = ox_r;
  assign out_res.place_y     = oy_r;
  assign out_res.space_count = oc_r;
  assign out_res.overflow    = oo_r;

  always_comb begin
    st_nxt    = st_r;
    req_nxt   = req_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    bw_nxt    = bw_r;
    bh_nxt    = bh_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    ovf_nxt   = ovf_r;
    pass_nxt  = pass_r;
    below_nxt = below_r;
    bf_nxt    = bf_r;
    bestx_nxt = bestx_r;
    besty_nxt = besty_r;
    app_nxt   = app_r;
    ov_nxt    = ov_r && !out_res.ready;
    of_nxt    = of_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oc_nxt    = oc_r;
    oo_nxt    = oo_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = cut.upd;
    re        = 1'b0;
    raddr     = idx_r[AW-1:0];
    case (st_r)
      S_IDLE: begin
        if (in_req.valid) begin
          req_nxt   = in_req.req_type;
          bx_nxt    = in_req.rect_x;
          by_nxt    = in_req.rect_y;
          bw_nxt    = in_req.rect_w;
          bh_nxt    = in_req.rect_h;
          idx_nxt   = '0;
          j_nxt     = '0;
          pass_nxt  = 1'b0;
          below_nxt = 1'b0;
          bf_nxt    = 1'b0;
          bestx_nxt = '0;
          besty_nxt = '0;
          if (in_req.req_type == REQ_RESET) begin
            we      = 1'b1;
            wdata   = '{x: '0, y: '0, w: aw_r, h: ah_r};
            cnt_nxt = CW'(1);
            ovf_nxt = 1'b0;
            st_nxt  = S_DONE;
          end else begin
            st_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx_r < cnt_r) begin
          re     = 1'b1;
          st_nxt = S_PROC;
        end else if (req_r == REQ_PLACE) begin
          st_nxt = S_STRIP;
        end else begin
          if (req_r == REQ_COMPACT) begin
            cnt_nxt = j_r;
          end
          st_nxt = S_DONE;
        end
      end
      S_PROC: begin
        st_nxt  = S_RD;
        idx_nxt = idx_r + CW'(1);
        case (req_r)
          REQ_FIND: begin
            if (rdata.w >= bw_r && rdata.h >= bh_r && (!bf_r || rdata.y < besty_r)) begin
              bf_nxt    = 1'b1;
              bestx_nxt = rdata.x;
              besty_nxt = rdata.y;
            end
          end
          REQ_PLACE: begin
            we        = 1'b1;
            waddr     = idx_r[AW-1:0];
            wdata     = cut.upd;
            below_nxt = below_r | cut.below;
            if (cut.app) begin
              app_nxt = cut.app_rect;
              idx_nxt = idx_r;
              st_nxt  = S_APP;
            end
          end
          REQ_COMPACT: begin
            if (!drop) begin
              we    = 1'b1;
              waddr = j_r[AW-1:0];
              wdata = rdata;
              j_nxt = j_r + CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_APP: begin
        if (cnt_r >= Depth) begin
          ovf_nxt = 1'b1;
        end else begin
          we      = 1'b1;
          waddr   = cnt_r[AW-1:0];
          wdata   = app_r;
          cnt_nxt = cnt_r + CW'(1);
        end
        idx_nxt = idx_r + CW'(1);
        st_nxt  = S_RD;
      end
      S_STRIP: begin
        if (!below_r) begin
          if (cnt_r >= Depth) begin
            ovf_nxt = 1'b1;
          end else begin
            we      = 1'b1;
            waddr   = cnt_r[AW-1:0];
            wdata   = strip;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          idx_nxt   = '0;
          below_nxt = 1'b0;
          st_nxt    = S_RD;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || out_res.ready) begin
          ov_nxt = 1'b1;
          of_nxt = bf_r;
          ox_nxt = bestx_r;
          oy_nxt = besty_r;
          oc_nxt = 8'(cnt_r);
          oo_nxt = ovf_r;
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    if (!rst_n) begin
      we    = 1'b1;
      waddr = '0;
      wdata = '{x: '0, y: '0, w: 13'd1024, h: 13'd1024};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cnt_r   <= CW'(1);
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
      aw_r    <= 13'd1024;
      ah_r    <= 13'd1024;
      ms_r    <= 13'd1;
      pass_r  <= 1'b0;
      below_r <= 1'b0;
      bf_r    <= 1'b0;
      idx_r   <= '0;
      j_r     <= '0;
      req_r   <= REQ_FIND;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
      pass_r  <= pass_nxt;
      below_r <= below_nxt;
      bf_r    <= bf_nxt;
      idx_r   <= idx_nxt;
      j_r     <= j_nxt;
      req_r   <= req_nxt;
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          CFG_WIDTH:  aw_r <= cfg_wr.data;
          CFG_HEIGHT: ah_r <= cfg_wr.data;
          CFG_SPLIT:  ms_r <= cfg_wr.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    bw_r    <= bw_nxt;
    bh_r    <= bh_nxt;
    bestx_r <= bestx_nxt;
    besty_r <= besty_nxt;
    app_r   <= app_nxt;
    of_r    <= of_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oc_r    <= oc_nxt;
    oo_r    <= oo_nxt;
  end

endmodule

FILE: design/rap_mem.sv
module rap_mem
  import rap_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  rect_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output rect_t         rdata
);

  rect_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/rap_cut.sv
module rap_cut
  import rap_pkg::*;
(
  input  rect_t              ent,
  input  coord_t             bx,
  input  coord_t             bw,
  input  logic [CoordW+1:0]  line,
  input  logic               strict,
  input  coord_t             min_split,
  input  coord_t             atlas_h,
  output cut_res_t           res
);

  calc_t right, bend, ln, ey, ex;
  logic  skip;

  always_comb begin
    ex    = ext(ent.x);
    ey    = ext(ent.y);
    right = ex + ext(ent.w);
    bend  = ext(bx) + ext(bw);
    ln    = calc_t'({1'b0, line});
    skip  = strict ? (ey >= ln) : (ey > ln);
    res.below    = ey >= ln;
    res.upd      = ent;
    res.app      = 1'b0;
    res.app_rect = '{x: ent.x, y: ent.y, w: sat13(ext(bx) - ex),
                     h: sat13(ext(atlas_h) - ey)};
    if (!skip) begin
      if (ex <= ext(bx)) begin
        if (bend < right) begin
          res.upd.x = sat13(bend);
          res.upd.w = sat13(right - bend);
          res.app   = (ext(bx) - ex) > ext(min_split);
        end else if (right > ext(bx)) begin
          res.upd.w = sat13(ext(bx) - ex);
        end
      end else begin
        if (right < bend) begin
          res.upd = '0;
        end else if (ex < bend) begin
          res.upd.x = sat13(bend);
          res.upd.w = sat13(right - bend);
        end
      end
    end
  end

endmodule
